// ----- src/ptre_pkg.sv -----
// Package with the beat types, entry layout constants and helpers of the page table block.
`timescale 1ns / 1ps
package ptre_pkg;

  localparam int PROCESS_COUNT = 4;
  localparam int PAGE_COUNT    = 4;
  localparam int PAGE_BYTES    = 16;

  localparam int PROC_W  = 2;
  localparam int PAGE_W  = 2;
  localparam int FRAME_W = 2;
  localparam int ENTRY_W = 8;
  localparam int SLOT_W  = 4;
  localparam int DEPTH   = 16;
  localparam int FADDR_W = 6;

  localparam int FRAME_LSB = 4;
  localparam int WRITE_BIT = 2;

  localparam logic [ENTRY_W-1:0] MASK_NOT_VALID   = 8'hF7;
  localparam logic [ENTRY_W-1:0] MASK_FRAME       = 8'h30;
  localparam logic [ENTRY_W-1:0] MASK_NOT_PRESENT = 8'hFD;
  localparam logic [ENTRY_W-1:0] MASK_NOT_FRAME   = 8'hCF;
  localparam logic [ENTRY_W-1:0] BIT_PRESENT      = 8'h02;
  localparam logic [ENTRY_W-1:0] BIT_WRITABLE     = 8'h04;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_SET    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [PROC_W-1:0]  process;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               valid_bit;
    logic               writable_bit;
    logic               present_bit;
    logic               referenced_bit;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [FADDR_W-1:0] frame_address;
    logic               write_allowed;
    logic               fetched;
    logic [FRAME_W-1:0] victim_frame;
    logic               victim_owner_found;
    logic [PROC_W-1:0]  victim_process;
    logic [PAGE_W-1:0]  victim_page;
  } out_beat_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [SLOT_W-1:0]  raddr;
  } mem_req_t;

  function automatic logic [SLOT_W-1:0] slot_of(logic [PROC_W-1:0] p, logic [PAGE_W-1:0] g);
    return SLOT_W'(int'(p) * PAGE_COUNT + int'(g));
  endfunction

  function automatic logic proc_ok(logic [PROC_W-1:0] p);
    return int'(p) < PROCESS_COUNT;
  endfunction

  function automatic logic page_ok(logic [PAGE_W-1:0] g);
    return int'(g) < PAGE_COUNT;
  endfunction

  function automatic logic [FADDR_W-1:0] frame_addr(logic [FRAME_W-1:0] f);
    return FADDR_W'(int'(f) * PAGE_BYTES);
  endfunction

  function automatic logic [FRAME_W-1:0] victim_after(logic [FRAME_W-1:0] v);
    logic [FRAME_W:0] n;
    n = {1'b0, v} + 1'b1;
    if (int'(n) >= PAGE_COUNT) begin
      n = n - (FRAME_W + 1)'(PAGE_COUNT);
    end
    if (n == '0) begin
      n = (FRAME_W + 1)'(1);
    end
    return n[FRAME_W-1:0];
  endfunction

endpackage

// ----- src/ptre_mem.sv -----
// Entry store: synchronous memory with one write and one read port and per-entry valid bits.
`timescale 1ns / 1ps
module ptre_mem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ptre_pkg::mem_req_t       req_i,
  output logic [ptre_pkg::ENTRY_W-1:0] rdata_o
);
  import ptre_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] raw_q;
  logic [DEPTH-1:0]   vld_q;
  logic               hit_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      raw_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        hit_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = hit_q ? raw_q : '0;

endmodule

// ----- src/page_table_translate_rr_evict.sv -----
// Top level of the page table block with round-robin frame replacement.
`timescale 1ns / 1ps
// The block handles one beat at a time: it takes an input beat only when idle, and the
// result waits in an output register, so the next beat may be taken while it is unread.
// Create and set finish in the dispatch state; a lookup reads its entry from the memory,
// and clearing valid bits reads each entry of the table and writes a set one back without
// the valid bit; neither reads when the table does not exist. A lookup of an entry that is
// not present evicts a frame: the scan reads all sixteen entries from the registered-read
// entry memory, one per cycle, before the looked-up entry is written back. The block is
// ready for the next beat in the cycle in which the result appears, and a result that is
// still unread holds the following one back. Reset clears the store's valid bits at once.
module page_table_translate_rr_evict (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptre_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptre_pkg::out_beat_t out_data_o
);
  import ptre_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_LWAIT = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_CLR   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  localparam logic [PROC_W-1:0] LAST_PROC = PROC_W'(PROCESS_COUNT - 1);
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);

  state_e             state_q, state_d;
  in_beat_t           item_q, item_d;
  out_beat_t          res_q, res_d;
  out_beat_t          out_q, out_d;
  logic               out_vld_q, out_vld_d;
  logic [3:0]         tbl_q, tbl_d;
  logic [FRAME_W-1:0] nv_q, nv_d;
  logic [FRAME_W-1:0] vic_q, vic_d;
  logic [ENTRY_W-1:0] ent_q, ent_d;
  logic [PROC_W-1:0]  cq_q, cq_d;
  logic [PAGE_W-1:0]  ci_q, ci_d;
  logic               iss_q, iss_d;
  logic               rv_q, rv_d;
  logic [PROC_W-1:0]  rq_q, rq_d;
  logic [PAGE_W-1:0]  ri_q, ri_d;
  logic [3:0]         tdone_q, tdone_d;
  logic               own_q, own_d;
  logic [PROC_W-1:0]  op_q, op_d;
  logic [PAGE_W-1:0]  og_q, og_d;

  mem_req_t           mreq;
  logic [ENTRY_W-1:0] rdata;
  logic [SLOT_W-1:0]  slot_s;
  logic               tbl_ok;

  ptre_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rdata_o(rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign slot_s = slot_of(item_q.process, item_q.page);
  assign tbl_ok = proc_ok(item_q.process) && page_ok(item_q.page) && tbl_q[item_q.process];

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    tbl_d     = tbl_q;
    nv_d      = nv_q;
    vic_d     = vic_q;
    ent_d     = ent_q;
    cq_d      = cq_q;
    ci_d      = ci_q;
    iss_d     = iss_q;
    rv_d      = rv_q;
    rq_d      = rq_q;
    ri_d      = ri_q;
    tdone_d   = tdone_q;
    own_d     = own_q;
    op_d      = op_q;
    og_d      = og_q;
    mreq      = '0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_d   = '0;
        state_d = S_DONE;
        case (kind_e'(item_q.kind))
          KIND_CREATE: begin
            if (proc_ok(item_q.process)) begin
              tbl_d[item_q.process] = 1'b1;
            end
          end
          KIND_SET: begin
            if (tbl_ok) begin
              mreq.we    = 1'b1;
              mreq.waddr = slot_s;
              mreq.wdata = {item_q.page, item_q.frame, item_q.valid_bit, item_q.writable_bit,
                            item_q.present_bit, item_q.referenced_bit};
            end
          end
          KIND_CLEAR: begin
            if (proc_ok(item_q.process) && tbl_q[item_q.process]) begin
              cq_d    = item_q.process;
              ci_d    = '0;
              iss_d   = 1'b1;
              rv_d    = 1'b0;
              state_d = S_CLR;
            end
          end
          KIND_LOOKUP: begin
            if (tbl_ok) begin
              mreq.re    = 1'b1;
              mreq.raddr = slot_s;
              state_d    = S_LWAIT;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_LWAIT: begin
        state_d = S_DONE;
        if (rdata != '0) begin
          if ((rdata & BIT_PRESENT) != '0) begin
            res_d.found         = 1'b1;
            res_d.frame_address = frame_addr(rdata[FRAME_LSB +: FRAME_W]);
            res_d.write_allowed = rdata[WRITE_BIT];
          end else begin
            ent_d   = rdata;
            vic_d   = nv_q;
            nv_d    = victim_after(nv_q);
            cq_d    = '0;
            ci_d    = '0;
            iss_d   = 1'b1;
            rv_d    = 1'b0;
            tdone_d = '0;
            own_d   = 1'b0;
            op_d    = '0;
            og_d    = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN, S_CLR: begin
        if (iss_q) begin
          mreq.re    = 1'b1;
          mreq.raddr = slot_of(cq_q, ci_q);
          rv_d       = 1'b1;
          rq_d       = cq_q;
          ri_d       = ci_q;
          if (ci_q == LAST_PAGE) begin
            ci_d = '0;
            if (state_q == S_CLR || cq_q == LAST_PROC) begin
              iss_d = 1'b0;
            end else begin
              cq_d = cq_q + 1'b1;
            end
          end else begin
            ci_d = ci_q + 1'b1;
          end
        end else begin
          rv_d = 1'b0;
        end

        if (rv_q && rdata != '0) begin
          if (state_q == S_CLR) begin
            mreq.we    = 1'b1;
            mreq.waddr = slot_of(rq_q, ri_q);
            mreq.wdata = rdata & MASK_NOT_VALID;
          end else if (tbl_q[rq_q] && !tdone_q[rq_q] &&
                       (rdata & MASK_FRAME) == (ENTRY_W'(vic_q) << FRAME_LSB)) begin
            mreq.we        = 1'b1;
            mreq.waddr     = slot_of(rq_q, ri_q);
            mreq.wdata     = rdata & MASK_NOT_PRESENT;
            tdone_d[rq_q]  = 1'b1;
            own_d          = 1'b1;
            op_d           = rq_q;
            og_d           = ri_q;
          end
        end

        if (!iss_q && !rv_q) begin
          state_d = (state_q == S_CLR) ? S_DONE : S_FIN;
        end
      end
      S_FIN: begin
        mreq.we    = 1'b1;
        mreq.waddr = slot_s;
        mreq.wdata = (ent_q & MASK_NOT_FRAME) | (ENTRY_W'(vic_q) << FRAME_LSB) | BIT_PRESENT;
        res_d.found              = 1'b1;
        res_d.frame_address      = frame_addr(vic_q);
        res_d.write_allowed      = |(ent_q & BIT_WRITABLE);
        res_d.fetched            = 1'b1;
        res_d.victim_frame       = vic_q;
        res_d.victim_owner_found = own_q;
        res_d.victim_process     = op_q;
        res_d.victim_page        = og_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      tbl_q     <= '0;
      nv_q      <= FRAME_W'(1);
      iss_q     <= 1'b0;
      rv_q      <= 1'b0;
      tdone_q   <= '0;
      own_q     <= 1'b0;
      cq_q      <= '0;
      ci_q      <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      tbl_q     <= tbl_d;
      nv_q      <= nv_d;
      iss_q     <= iss_d;
      rv_q      <= rv_d;
      tdone_q   <= tdone_d;
      own_q     <= own_d;
      cq_q      <= cq_d;
      ci_q      <= ci_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    vic_q  <= vic_d;
    ent_q  <= ent_d;
    rq_q   <= rq_d;
    ri_q   <= ri_d;
    op_q   <= op_d;
    og_q   <= og_d;
  end

endmodule
